// ----- rtl/core/sbl_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; every other file imports this package.
package sbl_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int PIX_W         = 8;
   localparam int CFG_W         = 12;
   localparam int ROW_W         = 12;
   localparam int CSR_IDX_W     = 1;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int GRAD_W        = 11;
   localparam int SQ_W          = 21;
   localparam int SUM_W         = 22;
   localparam int ROOT_W        = 8;
   localparam int RAD_W         = 2 * ROOT_W;
   localparam int SAT_LEVEL     = 65025;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_magnitude;
      logic             frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic produce;
      logic last;
   } tag_type;

endpackage

// ----- rtl/core/sbl_req_if.sv -----
// Pixel request channel: valid, ready and the pixel payload.
// Depends on sbl_pkg.
interface sbl_req_if import sbl_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sbl_rsp_if.sv -----
// Magnitude response channel: valid, ready and the result payload.
// Depends on sbl_pkg.
interface sbl_rsp_if import sbl_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sbl_window.sv -----
// Line memory (upper and middle rows in one word), 3x3 window and gradients.
// Read one cycle after issue, write back on stage exit, forward same column.
// Depends on sbl_pkg.
module sbl_window import sbl_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     accept,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
   input  logic [PIX_W-1:0]         pixel,
   input  tag_type                  tag,
   output logic                     stage1_valid,
   output logic                     grad_valid,
   output logic                     grad_last,
   output logic signed [GRAD_W-1:0] gx,
   output logic signed [GRAD_W-1:0] gy
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic               fwd_ff;

   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [PIX_W-1:0]   s1_pixel_ff;
   tag_type            s1_tag_ff;

   logic [2:0][PIX_W-1:0] w0_ff, w1_ff, c2;

   logic                     grad_valid_ff;
   logic                     grad_last_ff;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;

   logic                     load1, leave1;
   logic [2*PIX_W-1:0]       line_word, wr_data;
   logic [PIX_W+1:0]         xp, xn, yp, yn;
   logic signed [GRAD_W-1:0] gx_in, gy_in;

   assign load1     = !s1_valid_ff || adv;
   assign leave1    = s1_valid_ff && adv;
   assign line_word = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign c2[0]     = line_word[2*PIX_W-1:PIX_W];
   assign c2[1]     = line_word[PIX_W-1:0];
   assign c2[2]     = s1_pixel_ff;
   assign wr_data   = {c2[1], s1_pixel_ff};

   always_ff @(posedge clock) begin
      if (load1) begin
         rd_data_ff  <= line_mem[rd_col];
         fwd_ff      <= leave1 && (s1_col_ff == rd_col);
         fwd_data_ff <= wr_data;
      end
      if (leave1) begin
         line_mem[s1_col_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load1) begin
         s1_valid_ff <= accept;
      end
      if (load1) begin
         s1_col_ff   <= rd_col;
         s1_pixel_ff <= pixel;
         s1_tag_ff   <= tag;
      end
   end

   always_comb begin
      xp = (PIX_W+2)'(c2[0]) + ((PIX_W+2)'(c2[1]) << 1) + (PIX_W+2)'(c2[2]);
      xn = (PIX_W+2)'(w0_ff[0]) + ((PIX_W+2)'(w0_ff[1]) << 1) + (PIX_W+2)'(w0_ff[2]);
      yp = (PIX_W+2)'(w0_ff[2]) + ((PIX_W+2)'(w1_ff[2]) << 1) + (PIX_W+2)'(c2[2]);
      yn = (PIX_W+2)'(w0_ff[0]) + ((PIX_W+2)'(w1_ff[0]) << 1) + (PIX_W+2)'(c2[0]);
      gx_in = $signed({1'b0, xp}) - $signed({1'b0, xn});
      gy_in = $signed({1'b0, yp}) - $signed({1'b0, yn});
   end

   always_ff @(posedge clock) begin
      if (leave1) begin
         w0_ff <= w1_ff;
         w1_ff <= c2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_valid_ff <= 1'b0;
      end else if (adv) begin
         grad_valid_ff <= leave1 && s1_tag_ff.produce;
      end
      if (adv) begin
         grad_last_ff <= s1_tag_ff.last;
         gx_ff        <= gx_in;
         gy_ff        <= gy_in;
      end
   end

   assign stage1_valid = s1_valid_ff;
   assign grad_valid   = grad_valid_ff;
   assign grad_last    = grad_last_ff;
   assign gx           = gx_ff;
   assign gy           = gy_ff;

endmodule

// ----- rtl/core/sbl_magnitude.sv -----
// Squares, saturating sum and bit-per-stage floor square root pipeline.
// Depends on sbl_pkg.
module sbl_magnitude import sbl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic                     in_last,
   input  logic signed [GRAD_W-1:0] gx,
   input  logic signed [GRAD_W-1:0] gy,
   output logic                     out_valid,
   output logic [ROOT_W-1:0]        edge_magnitude,
   output logic                     frame_last
);

   logic                     sq_valid_ff, sq_last_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic signed [2*GRAD_W-1:0] gx_wide, gy_wide, gx_sq, gy_sq;
   logic [SUM_W-1:0]         sum;

   logic                     valid_ff [ROOT_W+1];
   logic                     last_ff  [ROOT_W+1];
   logic [RAD_W-1:0]         rad_ff   [ROOT_W+1];
   logic [ROOT_W-1:0]        root_ff  [ROOT_W+1];

   assign gx_wide = (2*GRAD_W)'(gx);
   assign gy_wide = (2*GRAD_W)'(gy);
   assign gx_sq   = gx_wide * gx_wide;
   assign gy_sq   = gy_wide * gy_wide;
   assign sum     = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff <= in_valid;
         valid_ff[0] <= sq_valid_ff;
      end
      if (adv) begin
         sq_last_ff <= in_last;
         sqx_ff     <= gx_sq[SQ_W-1:0];
         sqy_ff     <= gy_sq[SQ_W-1:0];
         last_ff[0] <= sq_last_ff;
         rad_ff[0]  <= (sum >= SUM_W'(SAT_LEVEL)) ? '1 : sum[RAD_W-1:0];
         root_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      logic [ROOT_W-1:0] trial;
      logic [RAD_W-1:0]  trial_sq;

      assign trial    = root_ff[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
      assign trial_sq = RAD_W'(trial) * RAD_W'(trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[j+1] <= valid_ff[j];
         end
         if (adv) begin
            last_ff[j+1] <= last_ff[j];
            rad_ff[j+1]  <= rad_ff[j];
            root_ff[j+1] <= (trial_sq <= rad_ff[j]) ? trial : root_ff[j];
         end
      end
   end

   assign out_valid      = valid_ff[ROOT_W];
   assign edge_magnitude = root_ff[ROOT_W];
   assign frame_last     = last_ff[ROOT_W];

endmodule

// ----- rtl/core/sobel_edge_magnitude.sv -----
// Sobel 3x3 gradient magnitude over a raster pixel stream: top level.
// Depends on sbl_pkg, sbl_req_if, sbl_rsp_if, sbl_window, sbl_magnitude.
//
// Takes one 8-bit pixel per cycle and returns floor(sqrt(gx^2 + gy^2)), capped
// at 255, for every interior pixel; border pixels give no result. The two
// previous rows sit in one line memory (upper and middle pixel per word) with
// one read and one write port; a pixel's read is issued as it is accepted, and
// its write-back happens as it leaves the next stage, with forwarding when the
// next pixel reads the same column. Sustained rate is one pixel per cycle; an
// accepted pixel passes window, gradient, squares, sum and eight root stages
// to a valid result. The input stalls only while a result is held on the
// output and the window stage is occupied. The line memory has no clearing
// pass; line data read before it is written feeds no result. Width and height
// registers must be written only while the block is idle; nothing enforces it.
module sobel_edge_magnitude import sbl_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   sbl_req_if.sink              req_chan,
   sbl_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   function automatic logic [COL_W-1:0] width_limit(input logic [CFG_W-1:0] w);
      int wi;
      wi = int'(w);
      if (wi < 3) wi = 3;
      if (wi > MAX_WIDTH) wi = MAX_WIDTH;
      return COL_W'(wi - 1);
   endfunction

   function automatic logic [ROW_W-1:0] height_limit(input logic [CFG_W-1:0] h);
      int hi;
      hi = int'(h);
      if (hi < 3) hi = 3;
      return ROW_W'(hi - 1);
   endfunction

   logic [COL_W-1:0] width_last_ff, width_last_in;
   logic [ROW_W-1:0] height_last_ff, height_last_in;
   logic [COL_W-1:0] col_ff, col_in, cur_col;
   logic [ROW_W-1:0] row_ff, row_in, cur_row;

   logic    adv, accept, col_end, row_end, stage1_valid;
   tag_type tag;

   logic                     grad_valid, grad_last, out_valid, out_last;
   logic signed [GRAD_W-1:0] gx, gy;
   logic [ROOT_W-1:0]        magnitude;

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_last_in  = width_limit(csr_write_data);
            CSR_IMAGE_HEIGHT: height_last_in = height_limit(csr_write_data);
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= width_limit(CFG_W'(WIDTH_RESET));
         height_last_ff <= height_limit(CFG_W'(HEIGHT_RESET));
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
      end
   end

   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = !stage1_valid || adv;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      cur_col = req_chan.data.frame_start ? '0 : col_ff;
      cur_row = req_chan.data.frame_start ? '0 : row_ff;
      col_end = cur_col >= width_last_ff;
      row_end = cur_row >= height_last_ff;
      tag.produce = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      tag.last    = row_end && col_end;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_end ? '0 : cur_col + COL_W'(1);
         if (col_end) begin
            row_in = row_end ? '0 : cur_row + ROW_W'(1);
         end else begin
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   sbl_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .accept       (accept),
      .rd_col       (cur_col),
      .pixel        (req_chan.data.pixel),
      .tag          (tag),
      .stage1_valid (stage1_valid),
      .grad_valid   (grad_valid),
      .grad_last    (grad_last),
      .gx           (gx),
      .gy           (gy)
   );

   sbl_magnitude u_magnitude (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (grad_valid),
      .in_last        (grad_last),
      .gx             (gx),
      .gy             (gy),
      .out_valid      (out_valid),
      .edge_magnitude (magnitude),
      .frame_last     (out_last)
   );

   assign rsp_chan.valid               = out_valid;
   assign rsp_chan.data.edge_magnitude = magnitude;
   assign rsp_chan.data.frame_last     = out_last;

endmodule

// ----- rtl/core/sbl_checker.sv -----
// Port-level checks for sobel_edge_magnitude, attached by bind.
// Depends on sbl_pkg and the top level's ports.
module sbl_checker import sbl_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a held response");

endmodule

bind sobel_edge_magnitude sbl_checker u_sbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
